// ----- src/fbce_pkg.sv -----
// package for the five-band crossover equalizer
// holds widths, coefficient table, register indexes and gain reset values
// no dependencies
package fbce_pkg;

  localparam int SampleWidthDef = 24;
  localparam int CoefFracDef    = 28;
  localparam int StateWidth     = 48;
  localparam int TableFrac      = 30;
  localparam int GainFrac       = 14;
  localparam int GainWidth      = 16;
  localparam int NumSplit       = 4;
  localparam int NumBiquad      = 16;
  localparam int BqIdxWidth     = 4;
  localparam int CfgIdxWidth    = 3;

  localparam logic [CfgIdxWidth-1:0] REG_GAIN_ONE   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_GAIN_TWO   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_GAIN_THREE = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_GAIN_FOUR  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_GAIN_FIVE  = 3'd4;

  localparam logic [GainWidth-1:0] GAIN_ONE_RST   = 16'd3277;
  localparam logic [GainWidth-1:0] GAIN_TWO_RST   = 16'd8192;
  localparam logic [GainWidth-1:0] GAIN_THREE_RST = 16'd31130;
  localparam logic [GainWidth-1:0] GAIN_FOUR_RST  = 16'd36045;
  localparam logic [GainWidth-1:0] GAIN_FIVE_RST  = 16'd29491;

  // coefficient codes within a crossover row
  localparam int C_B0L = 0;
  localparam int C_B1L = 1;
  localparam int C_B0H = 2;
  localparam int C_B1H = 3;
  localparam int C_A1  = 4;
  localparam int C_A2  = 5;

  // q2.30 crossover table
  function automatic logic signed [31:0] xover_q30(input logic [1:0] k, input int i);
    logic signed [31:0] t [4][6];
    t[0] = '{32'sd120774, 32'sd241549, 32'sd1057637584, -32'sd2115275168,
             -32'sd2115033619, 32'sd1041774893};
    t[1] = '{32'sd1848849, 32'sd3697698, 32'sd1010758057, -32'sd2021516114,
             -32'sd2017818416, 32'sd951471989};
    t[2] = '{32'sd18059424, 32'sd36118848, 32'sd877639360, -32'sd1755278719,
             -32'sd1719159871, 32'sd717655744};
    t[3] = '{32'sd154074937, 32'sd308149874, 32'sd519544818, -32'sd1039089636,
             -32'sd730939762, 32'sd273497686};
    return t[k][i];
  endfunction

endpackage

// ----- src/fbce_ram.sv -----
// generic single-port-write, single-read synchronous ram
// registered read; no dependencies
module fbce_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/five_band_crossover_equalizer.sv -----
// five-band crossover equalizer top level
// depends on fbce_pkg and fbce_ram
//
// One result per request. A sample runs through 16 biquads, one after the other.
// Each biquad first reads both delay memories, then uses the shared coefficient
// multiplier (five coefficient products, then the write-back). After that come
// the gain products and accumulation, then a rounding step that raises out_valid.
// The next request is taken only after out_ready has accepted the result, so
// out_ready stalls can hold it. Delay memories are cleared by a pass over all 16
// entries after reset, during which no sample is taken. Gain writes are always taken.
module five_band_crossover_equalizer
  import fbce_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SampleWidthDef,
  parameter int COEF_FRAC_BITS = CoefFracDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_mixed_sample,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CfgIdxWidth-1:0]         cfg_index,
  input  logic [GainWidth-1:0]           cfg_data
);

  localparam int Guard0     = 40 - SAMPLE_WIDTH;
  localparam int StateGuard = (Guard0 < COEF_FRAC_BITS) ? Guard0 : COEF_FRAC_BITS;
  localparam int ProdShift  = COEF_FRAC_BITS - StateGuard;
  localparam int SigWidth   = SAMPLE_WIDTH + 1;
  localparam int CoefWidth  = COEF_FRAC_BITS + 3;
  localparam int ProdWidth  = SigWidth + CoefWidth;
  localparam int AccWidth   = StateWidth + 3;
  localparam int SumWidth   = SigWidth + GainWidth + 4;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_GAIN  = 7'b0010000,
    S_ROUND = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [BqIdxWidth-1:0] bq_r;
  logic [2:0] step_r;
  logic [BqIdxWidth:0] clr_r;

  logic [GainWidth-1:0] gain_r [5];

  logic signed [SigWidth-1:0] x_in_r, lo_r, hi_r, y_r;
  logic signed [SigWidth-1:0] band_r [5];
  logic signed [AccWidth-1:0] acc1_r, acc2_r;
  logic signed [ProdWidth-1:0] prod_r;
  logic signed [SumWidth-1:0] sum_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;
  logic out_valid_r;

  logic we;
  logic [BqIdxWidth-1:0] waddr;
  logic [StateWidth-1:0] wd1, wd2, rd1, rd2;

  fbce_ram #(.Width(StateWidth), .Depth(NumBiquad)) u_ram1 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd1), .raddr(bq_r), .rdata(rd1));
  fbce_ram #(.Width(StateWidth), .Depth(NumBiquad)) u_ram2 (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd2), .raddr(bq_r), .rdata(rd2));

  function automatic logic signed [CoefWidth-1:0] coef(input logic [1:0] k, input int i);
    logic signed [32:0] v;
    v = 33'(xover_q30(k, i));
    if (TableFrac > COEF_FRAC_BITS)
      v = (v + (33'sd1 <<< (TableFrac - COEF_FRAC_BITS - 1))) >>> (TableFrac - COEF_FRAC_BITS);
    return CoefWidth'(v);
  endfunction

  function automatic logic signed [AccWidth-1:0] rnd(input logic signed [ProdWidth-1:0] p);
    logic signed [ProdWidth:0] t;
    t = ProdWidth'(p) + (ProdWidth+1)'(1 <<< (ProdShift - 1));
    if (ProdShift == 0)
      return AccWidth'(p);
    return AccWidth'(t >>> ProdShift);
  endfunction

  function automatic logic signed [StateWidth-1:0] sat48(input logic signed [AccWidth-1:0] v);
    if (v > AccWidth'(64'sh7FFF_FFFF_FFFF)) return {1'b0, {(StateWidth-1){1'b1}}};
    if (v < -AccWidth'(64'sh8000_0000_0000)) return {1'b1, {(StateWidth-1){1'b0}}};
    return StateWidth'(v);
  endfunction

  // biquad role within its splitter
  logic [1:0] split;
  logic is_hp, second;
  assign split  = bq_r[3:2];
  assign is_hp  = bq_r[1];
  assign second = bq_r[0];

  logic signed [SigWidth-1:0] bq_x;
  always_comb begin
    bq_x = x_in_r;
    if (second) bq_x = is_hp ? hi_r : lo_r;
  end

  // multiplier operands per step: 0 b0*x, 2 b1*x, 3 a1*y, 4 b2*x, 5 a2*y
  logic signed [CoefWidth-1:0] mc;
  logic signed [SigWidth-1:0] mx;
  always_comb begin
    mc = '0;
    mx = bq_x;
    case (step_r)
      3'd2: mc = coef(split, is_hp ? C_B1H : C_B1L);
      3'd3: begin mc = coef(split, C_A1); mx = y_r; end
      3'd5: begin mc = coef(split, C_A2); mx = y_r; end
      default: mc = coef(split, is_hp ? C_B0H : C_B0L);
    endcase
  end

  // y from acc: round by guard and saturate
  logic signed [AccWidth-1:0] yfull;
  logic signed [SigWidth-1:0] ysat;
  always_comb begin
    yfull = (acc1_r + AccWidth'(1 <<< (StateGuard - 1))) >>> StateGuard;
    if (yfull > AccWidth'((1 <<< (SigWidth-1)) - 1)) ysat = {1'b0, {(SigWidth-1){1'b1}}};
    else if (yfull < -AccWidth'(1 <<< (SigWidth-1))) ysat = {1'b1, {(SigWidth-1){1'b0}}};
    else ysat = SigWidth'(yfull);
  end

  logic signed [AccWidth-1:0] pr;
  assign pr = rnd(prod_r);

  logic signed [SumWidth-1:0] sum_rnd;
  logic signed [SAMPLE_WIDTH-1:0] sum_sat;
  always_comb begin
    sum_rnd = (sum_r + SumWidth'(1 <<< (GainFrac - 1))) >>> GainFrac;
    if (sum_rnd > SumWidth'((1 <<< (SAMPLE_WIDTH-1)) - 1))
      sum_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    else if (sum_rnd < -SumWidth'(1 <<< (SAMPLE_WIDTH-1)))
      sum_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    else sum_sat = SAMPLE_WIDTH'(sum_rnd);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_mixed_sample = out_r;

  // sequence per biquad: READ (mem) then MUL steps 0..6
  // step0 prod=b0x; 1 acc1=rd1+rnd; prod ready next; ...
  assign we    = (state_r == S_CLEAR) || (state_r == S_MUL && step_r == 3'd6);
  assign waddr = (state_r == S_CLEAR) ? clr_r[BqIdxWidth-1:0] : bq_r;
  assign wd1   = (state_r == S_CLEAR) ? '0 : sat48(acc1_r);
  assign wd2   = (state_r == S_CLEAR) ? '0 : sat48(acc2_r - pr);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == (BqIdxWidth+1)'(NumBiquad - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_READ;
      S_READ:  state_nxt = S_MUL;
      S_MUL:   if (step_r == 3'd6) state_nxt = (bq_r == 4'd15) ? S_GAIN : S_READ;
      S_GAIN:  if (step_r == 3'd5) state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // biquad order inside splitter: lp1, hp1, lp2, hp2
  function automatic logic [BqIdxWidth-1:0] next_bq(input logic [BqIdxWidth-1:0] b);
    case (b[1:0])
      2'd0: return {b[3:2], 2'd2};
      2'd2: return {b[3:2], 2'd1};
      2'd1: return {b[3:2], 2'd3};
      default: return {b[3:2] + 2'd1, 2'd0};
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      bq_r        <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      gain_r[0]   <= GAIN_ONE_RST;
      gain_r[1]   <= GAIN_TWO_RST;
      gain_r[2]   <= GAIN_THREE_RST;
      gain_r[3]   <= GAIN_FOUR_RST;
      gain_r[4]   <= GAIN_FIVE_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GAIN_ONE:   gain_r[0] <= cfg_data;
          REG_GAIN_TWO:   gain_r[1] <= cfg_data;
          REG_GAIN_THREE: gain_r[2] <= cfg_data;
          REG_GAIN_FOUR:  gain_r[3] <= cfg_data;
          REG_GAIN_FIVE:  gain_r[4] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: begin
          bq_r <= '0;
          step_r <= '0;
          x_in_r <= SigWidth'(in_sample);
        end
        S_READ: step_r <= '0;
        S_MUL: begin
          step_r <= (step_r == 3'd6) ? 3'd0 : step_r + 3'd1;
          case (step_r)
            3'd0: prod_r <= mx * mc;
            3'd1: acc1_r <= AccWidth'(signed'(rd1)) + pr;
            3'd2: begin
              y_r <= ysat;
              prod_r <= mx * mc;
            end
            3'd3: begin
              acc1_r <= AccWidth'(signed'(rd2)) + pr;
              prod_r <= mx * mc;
            end
            3'd4: begin
              acc1_r <= acc1_r - pr;
              prod_r <= mx * mc;
            end
            3'd5: begin
              acc2_r <= pr;
              prod_r <= mx * mc;
            end
            default: begin
              acc2_r <= acc2_r - pr;
            end
          endcase
          if (step_r == 3'd6) begin
            bq_r <= next_bq(bq_r);
            case (bq_r[1:0])
              2'd0: lo_r <= y_r;
              2'd2: hi_r <= y_r;
              2'd1: band_r[split] <= y_r;
              default: begin
                x_in_r <= y_r;
                if (split == 2'd3) band_r[4] <= y_r;
              end
            endcase
          end
        end
        S_GAIN: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd0) sum_r <= '0;
          else sum_r <= sum_r + SumWidth'(prod_r);
          if (step_r != 3'd5)
            prod_r <= ProdWidth'(band_r[step_r]) *
                      ProdWidth'($signed({1'b0, gain_r[step_r]}));
        end
        S_ROUND: begin
          out_r <= sum_sat;
          out_valid_r <= 1'b1;
        end
        S_OUT: if (out_ready) out_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for five_band_crossover_equalizer
// predicts every mixed sample with a bit-exact model of the 16-biquad chain and gain mix
// depends on fbce_pkg and the rtl under src

module testbench;
  import fbce_pkg::*;

  localparam int SW = SampleWidthDef;
  localparam int StateGuard = 16;
  localparam int ProdShift = CoefFracDef - StateGuard;
  localparam int SettleCycles = 200;
  localparam int WatchdogLimit = 20000;
  localparam int HoldOffCycles = 3000;
  localparam int RandPerPhase = 110;

  typedef struct {
    logic signed [SW-1:0] sample;
    bit                   known;
    logic signed [SW-1:0] mixed;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [SW-1:0] in_sample, out_mixed_sample;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [GainWidth-1:0] cfg_data;

  longint coef [NumSplit][6];
  longint dly_a [NumBiquad];
  longint dly_b [NumBiquad];
  logic [GainWidth-1:0] band_gain [5];
  logic signed [SW-1:0] mixed_q [$];
  int errors;
  int idle_cycles;
  bit hold_off_req;
  stim_row_t rows [$];

  five_band_crossover_equalizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_mixed_sample(out_mixed_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint rnd_shift(longint v, int s);
    longint t;
    if (s == 0) return v;
    t = v >>> (s - 1);
    return (t + 1) >>> 1;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint biquad(int n, longint x, int k, bit high);
    longint c0, c1, c3, c4, acc, y;
    c0 = high ? coef[k][C_B0H] : coef[k][C_B0L];
    c1 = high ? coef[k][C_B1H] : coef[k][C_B1L];
    c3 = coef[k][C_A1];
    c4 = coef[k][C_A2];
    acc = rnd_shift(x * c0, ProdShift) + dly_a[n];
    y = clip(rnd_shift(acc, StateGuard), SW + 1);
    dly_a[n] = clip(rnd_shift(x * c1, ProdShift) + dly_b[n]
                    - rnd_shift(y * c3, ProdShift), StateWidth);
    dly_b[n] = clip(rnd_shift(x * c0, ProdShift) - rnd_shift(y * c4, ProdShift), StateWidth);
    return y;
  endfunction

  function automatic logic signed [SW-1:0] mix_sample(logic signed [SW-1:0] s);
    longint x, lo, hi, sum;
    longint band [5];
    x = s;
    for (int k = 0; k < NumSplit; k++) begin
      lo = biquad(4 * k, x, k, 1'b0);
      hi = biquad(4 * k + 2, x, k, 1'b1);
      band[k] = biquad(4 * k + 1, lo, k, 1'b0);
      x = biquad(4 * k + 3, hi, k, 1'b1);
    end
    band[4] = x;
    sum = 0;
    for (int b = 0; b < 5; b++) sum += band[b] * longint'(band_gain[b]);
    return SW'(clip(rnd_shift(sum, GainFrac), SW));
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_sample(logic signed [SW-1:0] s, bit known, logic signed [SW-1:0] mixed);
    logic signed [SW-1:0] pred;
    int gap;
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = mix_sample(s);
    if (known && pred !== mixed) begin
      $display("%0t predictor check: expected %0d actual %0d", $time, mixed, pred);
      errors++;
    end
    mixed_q.push_back(known ? mixed : pred);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_gain(logic [CfgIdxWidth-1:0] idx, logic [GainWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_GAIN_FIVE) band_gain[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (mixed_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic rand_phase(int count);
    logic signed [SW-1:0] s;
    int run;
    run = 0;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: s = SW'($urandom);
        1: s = $urandom_range(0, 1) ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
        2: s = SW'(int'($urandom_range(0, 4095)) - 2048);
        default: begin
          // square-ish wave to drive the low bands hard
          run++;
          s = (run % 16 < 8) ? SW'($urandom_range(6000000, 8388607))
                             : -SW'($urandom_range(6000000, 8388608));
        end
      endcase
      if (i == count / 2 && !hold_off_req) hold_off_req = 1'b1;
      send_sample(s, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mixed_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %0d", $time, out_mixed_sample);
        errors++;
      end else begin
        if (out_mixed_sample !== mixed_q[0]) begin
          $display("%0t mixed_sample mismatch: expected %0d actual %0d",
                   $time, mixed_q[0], out_mixed_sample);
          errors++;
        end
        void'(mixed_q.pop_front());
      end
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end
      gap = gap_len();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic signed [SW-1:0] smax, smin;
    smax = {1'b0, {(SW-1){1'b1}}};
    smin = {1'b1, {(SW-1){1'b0}}};
    errors = 0;
    idle_cycles = 0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int k = 0; k < NumSplit; k++)
      for (int i = 0; i < 6; i++)
        coef[k][i] = rnd_shift(longint'(xover_q30(k[1:0], i)), TableFrac - CoefFracDef);
    for (int n = 0; n < NumBiquad; n++) begin
      dly_a[n] = 0;
      dly_b[n] = 0;
    end
    band_gain = '{GAIN_ONE_RST, GAIN_TWO_RST, GAIN_THREE_RST, GAIN_FOUR_RST, GAIN_FIVE_RST};

    // silence out of reset gives silence; then full-scale, alternating, small and bit-pattern samples
    rows.push_back('{'0, 1'b1, '0});
    rows.push_back('{'0, 1'b1, '0});
    rows.push_back('{smax, 1'b0, '0});
    rows.push_back('{smax, 1'b0, '0});
    rows.push_back('{smax, 1'b0, '0});
    rows.push_back('{smin, 1'b0, '0});
    rows.push_back('{smin, 1'b0, '0});
    rows.push_back('{smin, 1'b0, '0});
    for (int i = 0; i < 6; i++) rows.push_back('{(i % 2) ? smin : smax, 1'b0, '0});
    rows.push_back('{-1, 1'b0, '0});
    rows.push_back('{1, 1'b0, '0});
    rows.push_back('{24'h555555, 1'b0, '0});
    rows.push_back('{24'hAAAAAA, 1'b0, '0});
    rows.push_back('{'0, 1'b0, '0});
    rows.push_back('{'0, 1'b0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].mixed);
    rand_phase(RandPerPhase);
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      for (int r = 0; r <= REG_GAIN_FIVE; r++) begin
        case (p)
          0: write_gain(CfgIdxWidth'(r), '0);
          1: write_gain(CfgIdxWidth'(r), '1);
          2: write_gain(CfgIdxWidth'(r), GainWidth'($urandom));
          default: write_gain(CfgIdxWidth'(r), 16'd16384);
        endcase
      end
      // indexes past the last register must be ignored
      for (int r = REG_GAIN_FIVE + 1; r < (1 << CfgIdxWidth); r++)
        write_gain(CfgIdxWidth'(r), GainWidth'($urandom));
      if (p == 0) begin
        send_sample(smax, 1'b1, '0);
        send_sample(smin, 1'b1, '0);
      end
      rand_phase(RandPerPhase);
      wait_drain();
    end

    if (errors == 0 && mixed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
